[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros - shared concurrent assertion helpers
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent on the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/slbsm_pkg.sv]
// ----------------------------------------------------------------------------
// slbsm_pkg - bank switch mapper types and constants
// bus command codes, target codes, register selects and address constants
// ----------------------------------------------------------------------------
package slbsm_pkg;

  typedef enum logic [1:0] {
    CMD_CPU_RD = 2'd0,
    CMD_CPU_WR = 2'd1,
    CMD_PPU_RD = 2'd2,
    CMD_PPU_WR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    TGT_NONE    = 3'd0,
    TGT_PRG_ROM = 3'd1,
    TGT_PRG_RAM = 3'd2,
    TGT_CHR     = 3'd3,
    TGT_NT_RAM  = 3'd4
  } target_t;

  // mapper register chosen by cpu address bits 14..13 on the fifth serial write
  typedef enum logic [1:0] {
    SEL_CTRL = 2'd0,
    SEL_CHR0 = 2'd1,
    SEL_CHR1 = 2'd2,
    SEL_PRG  = 2'd3
  } reg_sel_t;

  // configuration register indexes
  localparam logic [1:0] CFG_PRG_MASK = 2'd0;
  localparam logic [1:0] CFG_CHR_MASK = 2'd1;
  localparam logic [1:0] CFG_CHR_RAM  = 2'd2;

  localparam int          NAMETABLE_RAM_BYTES = 2048;
  localparam logic [2:0]  SHIFT_LEN           = 3'd5;
  localparam logic [1:0]  PRG_MODE_FIX_LAST   = 2'd3;
  localparam logic [3:0]  PRG_MASK_RST        = 4'hF;
  localparam logic [4:0]  CHR_MASK_RST        = 5'h1F;

  typedef struct packed {
    cmd_t        command;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
  } bus_beat_t;

endpackage

[hw/rtl/serial_loaded_bank_switch_mapper_core.sv]
// ----------------------------------------------------------------------------
// serial_loaded_bank_switch_mapper_core - serially loaded bank switch mapper
// translates cpu and ppu bus accesses into prg rom, prg ram, chr and
// nametable ram offsets, with a five-bit serial register load port
// ----------------------------------------------------------------------------
// usage:
//   in_*   one bus access per beat: command, bus_address, write_byte
//   out_*  one result per access: target, byte offset, write_enable and
//          the mirroring bits as they stand after that access
//   cfg_*  rom/ram geometry, written with cfg_we while the block is idle
// flow: each access passes through the input register, then the result
//   register; one access per cycle while the receiver keeps taking results,
//   set by the single pass from the input register through the bank logic
//   and serial register update into the result register
// a stalled receiver holds the result register; the input register keeps
//   filling behind it, so in_ready drops only when both are full
// reset: both stages empty, serial register cleared, prg mode fixes the last
//   bank, bank and mirroring registers cleared, masks at full size, chr rom
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module serial_loaded_bank_switch_mapper_core
  import slbsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_bus_address,
  input  logic [7:0]  in_write_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_target,
  output logic [17:0] out_byte_offset,
  output logic        out_write_enable,
  output logic [1:0]  out_mirroring_mode,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_wdata
);

  // configuration
  logic [3:0] prg_bank_mask_r;
  logic [4:0] chr_bank_mask_r;
  logic       chr_is_ram_r;

  // mapper state
  logic [4:0] shift_value_r,   shift_value_nxt;
  logic [2:0] shift_count_r,   shift_count_nxt;
  logic [1:0] mirroring_r,     mirroring_nxt;
  logic [1:0] prg_mode_r,      prg_mode_nxt;
  logic       chr_4k_r,        chr_4k_nxt;
  logic [4:0] chr_low_r,       chr_low_nxt;
  logic [4:0] chr_high_r,      chr_high_nxt;
  logic [3:0] prg_bank_r,      prg_bank_nxt;
  logic       prg_ram_on_r,    prg_ram_on_nxt;

  // pipeline
  logic       in_vld_r;
  bus_beat_t  beat_r;
  logic       out_vld_r;
  target_t    target_r,  target_nxt;
  logic [17:0] mapped_r, mapped_nxt;
  logic       we_r,      we_nxt;
  logic [1:0] mirr_out_r;

  logic       advance;
  logic       in_fire;

  // stage two moves when the result register is free or being drained
  assign advance  = !out_vld_r || out_ready;
  assign in_ready = !in_vld_r || advance;
  assign in_fire  = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // translation and serial register update
  // --------------------------------------------------------------------------
  logic        is_cpu, is_write;
  logic [15:0] addr;
  logic [13:0] pa;
  logic        upper;
  logic [3:0]  prg_sel;
  logic [3:0]  prg_page;
  logic [4:0]  chr_bank;
  logic [12:0] nt_off;
  logic [4:0]  shifted;
  logic [2:0]  count_inc;
  logic        step;

  always_comb begin
    addr      = beat_r.bus_address;
    pa        = addr[13:0];
    is_cpu    = (beat_r.command == CMD_CPU_RD) || (beat_r.command == CMD_CPU_WR);
    is_write  = (beat_r.command == CMD_CPU_WR) || (beat_r.command == CMD_PPU_WR);
    upper     = addr[14];
    step      = in_vld_r && advance;

    case (prg_mode_r)
      2'd0, 2'd1: prg_sel = {prg_bank_r[3:1], upper};
      2'd2:       prg_sel = upper ? prg_bank_r : 4'd0;
      default:    prg_sel = upper ? prg_bank_mask_r : prg_bank_r;
    endcase
    prg_page = prg_sel & prg_bank_mask_r;

    // 8k chr mode drops bit 0 of the low bank
    if (chr_4k_r) begin
      chr_bank = (pa[12] ? chr_high_r : chr_low_r) & chr_bank_mask_r;
    end else begin
      chr_bank = chr_low_r & chr_bank_mask_r & 5'h1E;
    end

    nt_off = 13'(pa[12:0] % NAMETABLE_RAM_BYTES);

    target_nxt = TGT_NONE;
    mapped_nxt = '0;
    we_nxt     = 1'b0;
    if (is_cpu) begin
      if (addr[15]) begin
        if (!is_write) begin
          target_nxt = TGT_PRG_ROM;
          mapped_nxt = {prg_page, addr[13:0]};
        end
      end else if (addr[14] && addr[13]) begin
        target_nxt = TGT_PRG_RAM;
        mapped_nxt = {5'd0, addr[12:0]};
        we_nxt     = is_write && prg_ram_on_r;
      end
    end else if (!pa[13]) begin
      target_nxt = TGT_CHR;
      if (chr_4k_r) begin
        mapped_nxt = {1'b0, chr_bank, pa[11:0]};
      end else begin
        mapped_nxt = {1'b0, chr_bank[4:1], pa[12:0]};
      end
      we_nxt = is_write && chr_is_ram_r;
    end else begin
      target_nxt = TGT_NT_RAM;
      mapped_nxt = {5'd0, nt_off};
      we_nxt     = is_write;
    end

    // serial load register, filled lsb first
    shifted   = {beat_r.write_byte[0], shift_value_r[4:1]};
    count_inc = shift_count_r + 3'd1;

    shift_value_nxt = shift_value_r;
    shift_count_nxt = shift_count_r;
    mirroring_nxt   = mirroring_r;
    prg_mode_nxt    = prg_mode_r;
    chr_4k_nxt      = chr_4k_r;
    chr_low_nxt     = chr_low_r;
    chr_high_nxt    = chr_high_r;
    prg_bank_nxt    = prg_bank_r;
    prg_ram_on_nxt  = prg_ram_on_r;

    if (step && (beat_r.command == CMD_CPU_WR) && addr[15]) begin
      if (beat_r.write_byte[7]) begin
        shift_value_nxt = '0;
        shift_count_nxt = '0;
        prg_mode_nxt    = PRG_MODE_FIX_LAST;
      end else if (count_inc >= SHIFT_LEN) begin
        shift_value_nxt = '0;
        shift_count_nxt = '0;
        case (reg_sel_t'(addr[14:13]))
          SEL_CTRL: begin
            mirroring_nxt = shifted[1:0];
            prg_mode_nxt  = shifted[3:2];
            chr_4k_nxt    = shifted[4];
          end
          SEL_CHR0: chr_low_nxt  = shifted;
          SEL_CHR1: chr_high_nxt = shifted;
          SEL_PRG: begin
            prg_bank_nxt   = shifted[3:0];
            prg_ram_on_nxt = !shifted[4];
          end
          default: ;
        endcase
      end else begin
        shift_value_nxt = shifted;
        shift_count_nxt = count_inc;
      end
    end
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_bank_mask_r <= PRG_MASK_RST;
      chr_bank_mask_r <= CHR_MASK_RST;
      chr_is_ram_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRG_MASK: prg_bank_mask_r <= cfg_wdata[3:0];
        CFG_CHR_MASK: chr_bank_mask_r <= cfg_wdata;
        CFG_CHR_RAM:  chr_is_ram_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_value_r <= '0;
      shift_count_r <= '0;
      mirroring_r   <= '0;
      prg_mode_r    <= PRG_MODE_FIX_LAST;
      chr_4k_r      <= 1'b0;
      chr_low_r     <= '0;
      chr_high_r    <= '0;
      prg_bank_r    <= '0;
      prg_ram_on_r  <= 1'b0;
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      shift_value_r <= shift_value_nxt;
      shift_count_r <= shift_count_nxt;
      mirroring_r   <= mirroring_nxt;
      prg_mode_r    <= prg_mode_nxt;
      chr_4k_r      <= chr_4k_nxt;
      chr_low_r     <= chr_low_nxt;
      chr_high_r    <= chr_high_nxt;
      prg_bank_r    <= prg_bank_nxt;
      prg_ram_on_r  <= prg_ram_on_nxt;
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      beat_r <= '{command: cmd_t'(in_command), bus_address: in_bus_address,
                  write_byte: in_write_byte};
    end
    if (step) begin
      target_r   <= target_nxt;
      mapped_r   <= mapped_nxt;
      we_r       <= we_nxt;
      mirr_out_r <= mirroring_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_target         = target_r;
  assign out_byte_offset    = mapped_r;
  assign out_write_enable   = we_r;
  assign out_mirroring_mode = mirr_out_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `ASSERT_CLK(a_shift_count_range, shift_count_r < SHIFT_LEN,
              "serial shift count passed five")
  `ASSERT_CLK(a_we_has_target, !(out_vld_r && we_r) || (target_r != TGT_NONE),
              "write enable without a target memory")
  `ASSERT_CLK(a_rom_read_only, !(out_vld_r && target_r == TGT_PRG_ROM) || !we_r,
              "prg rom marked writable")
  `ASSERT_NEXT(a_stall_holds_input, in_vld_r && out_vld_r && !out_ready, in_vld_r,
               "input stage lost a beat while the result stage stalled")
  `ASSERT_NEXT(a_reset_write, step && beat_r.command == CMD_CPU_WR &&
               beat_r.bus_address[15] && beat_r.write_byte[7],
               shift_count_r == 3'd0 && prg_mode_r == PRG_MODE_FIX_LAST,
               "serial reset write did not clear the load register")

endmodule

[bench/serial_loaded_bank_switch_mapper_core_test.sv]
// ----------------------------------------------------------------------------
// serial_loaded_bank_switch_mapper_core_test - bank switch mapper bench
// feeds cpu and ppu bus accesses with random gaps against random receiver
// stalls, predicts every translated access from a behavioral mapper model and
// checks each result beat field by field, over several rom/ram geometries
// ----------------------------------------------------------------------------
module serial_loaded_bank_switch_mapper_core_test;
  import slbsm_pkg::*;

  localparam int PHASE_ITEMS = 240;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AFTER  = 600;
  localparam int HOLD_CYCLES = 240;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    target_t     target;
    logic [17:0] offset;
    logic        we;
    logic [1:0]  mirror;
  } access_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = '0;
  logic [15:0] in_bus_address = '0;
  logic [7:0]  in_write_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_target;
  logic [17:0] out_byte_offset;
  logic        out_write_enable;
  logic [1:0]  out_mirroring_mode;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_PRG_MASK;
  logic [4:0]  cfg_wdata = '0;

  serial_loaded_bank_switch_mapper_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_bus_address     (in_bus_address),
    .in_write_byte      (in_write_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_target         (out_target),
    .out_byte_offset    (out_byte_offset),
    .out_write_enable   (out_write_enable),
    .out_mirroring_mode (out_mirroring_mode),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #1 clk = ~clk;

  // mapper model: geometry
  logic [3:0] prg_mask_m;
  logic [4:0] chr_mask_m;
  logic       chr_ram_m;
  // mapper model: serial port and bank registers
  logic [4:0] shift_bits;
  logic [2:0] shift_len;
  logic [1:0] mirror_bits;
  logic [1:0] prg_mode;
  logic       chr_4k;
  logic [4:0] chr_lo;
  logic [4:0] chr_hi;
  logic [3:0] prg_page;
  logic       prg_ram_en;

  bus_beat_t      bus_beats_pending[$];
  access_result_t expected_results[$];
  access_result_t want;

  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  int mismatches = 0;
  int cycle_count = 0;
  int sent_count = 0;
  int send_wait = 0;
  int send_calm = 0;
  int recv_wait = 0;
  int recv_calm = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit next_valid;
  bus_beat_t beat;

  // translates one access and advances the serial register and bank state
  function automatic access_result_t translate_access(cmd_t cmd, logic [15:0] addr,
                                                      logic [7:0] data);
    access_result_t r;
    logic [13:0] pa;
    logic [3:0]  prg_sel;
    logic [4:0]  chr_sel;
    int          nt_index;
    pa = addr[13:0];
    r.target = TGT_NONE;
    r.offset = '0;
    r.we = 1'b0;
    if (cmd == CMD_CPU_RD || cmd == CMD_CPU_WR) begin
      if (addr[15] && cmd == CMD_CPU_WR) begin
        if (data[7]) begin
          shift_bits = '0;
          shift_len = '0;
          prg_mode = PRG_MODE_FIX_LAST;
        end else begin
          shift_bits = {data[0], shift_bits[4:1]};
          shift_len = shift_len + 3'd1;
          if (shift_len == SHIFT_LEN) begin
            case (reg_sel_t'(addr[14:13]))
              SEL_CTRL: begin
                mirror_bits = shift_bits[1:0];
                prg_mode = shift_bits[3:2];
                chr_4k = shift_bits[4];
              end
              SEL_CHR0: chr_lo = shift_bits;
              SEL_CHR1: chr_hi = shift_bits;
              default: begin
                prg_page = shift_bits[3:0];
                prg_ram_en = !shift_bits[4];
              end
            endcase
            shift_bits = '0;
            shift_len = '0;
          end
        end
      end else if (addr[15]) begin
        // 32k modes pair banks, otherwise one half is pinned
        if (!prg_mode[1])
          prg_sel = {prg_page[3:1], addr[14]};
        else if (prg_mode == PRG_MODE_FIX_LAST)
          prg_sel = addr[14] ? prg_mask_m : prg_page;
        else
          prg_sel = addr[14] ? prg_page : 4'd0;
        prg_sel = prg_sel & prg_mask_m;
        r.target = TGT_PRG_ROM;
        r.offset = {prg_sel, addr[13:0]};
      end else if (addr[14:13] == 2'b11) begin
        // 6000h..7fffh, offset is the low 13 bits
        r.target = TGT_PRG_RAM;
        r.offset = {5'd0, addr[12:0]};
        r.we = (cmd == CMD_CPU_WR) && prg_ram_en;
      end
    end else if (!pa[13]) begin
      if (chr_4k) begin
        chr_sel = (pa[12] ? chr_hi : chr_lo) & chr_mask_m;
        r.offset = {1'b0, chr_sel, pa[11:0]};
      end else begin
        chr_sel = chr_lo & 5'h1E & chr_mask_m;
        r.offset = {1'b0, chr_sel, 12'h000} | {5'd0, pa[12:0]};
      end
      r.target = TGT_CHR;
      r.we = (cmd == CMD_PPU_WR) && chr_ram_m;
    end else begin
      nt_index = (pa - 14'h2000) % NAMETABLE_RAM_BYTES;
      r.target = TGT_NT_RAM;
      r.offset = nt_index[17:0];
      r.we = (cmd == CMD_PPU_WR);
    end
    r.mirror = mirror_bits;
    return r;
  endfunction

  // gap before the next beat: mostly random, with runs of back-to-back beats
  task automatic draw_wait(inout int calm_left, output int cycles);
    if (calm_left > 0) begin
      calm_left--;
      cycles = 0;
    end else if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(16, 64);
      cycles = 0;
    end else begin
      cycles = $urandom_range(0, 16);
    end
  endtask

  task automatic queue_beat(cmd_t cmd, logic [15:0] addr, logic [7:0] data);
    bus_beat_t b;
    b.command = cmd;
    b.bus_address = addr;
    b.write_byte = data;
    bus_beats_pending.push_back(b);
  endtask

  // five writes lsb first; only the address of the last one picks the register
  task automatic queue_serial_load(logic [15:0] addr, logic [4:0] value);
    logic [15:0] a;
    logic [7:0]  fill;
    for (int i = 0; i < SHIFT_LEN; i++) begin
      a = 16'($urandom);
      fill = 8'($urandom);
      queue_beat(CMD_CPU_WR, (i == SHIFT_LEN - 1) ? addr : {1'b1, a[14:0]},
                 {1'b0, fill[6:1], value[i]});
    end
  endtask

  task automatic add_random_traffic();
    int          pick;
    int          n;
    logic [15:0] a;
    logic [7:0]  d;
    logic [1:0]  c;
    pick = $urandom_range(0, 99);
    a = 16'($urandom);
    d = 8'($urandom);
    if (pick < 35) begin
      if ($urandom_range(0, 2) == 0)
        queue_beat(CMD_CPU_WR, {1'b1, a[14:0]}, {1'b1, d[6:0]});
      queue_serial_load({1'b1, a[14:0]}, d[4:0]);
    end else if (pick < 40) begin
      queue_beat(CMD_CPU_WR, {1'b1, a[14:0]}, {1'b1, d[6:0]});
    end else if (pick < 44) begin
      // load cut short, leaves the shift register misaligned
      n = $urandom_range(1, 4);
      repeat (n) begin
        a = 16'($urandom);
        d = 8'($urandom);
        queue_beat(CMD_CPU_WR, {1'b1, a[14:0]}, {1'b0, d[6:0]});
      end
    end else if (pick < 48) begin
      c = 2'($urandom);
      queue_beat(cmd_t'(c), a, d);
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        a = 16'($urandom);
        d = 8'($urandom);
        c = 2'($urandom);
        // cpu writes stay off the serial port here
        if (cmd_t'(c) == CMD_CPU_WR)
          a[15] = 1'b0;
        queue_beat(cmd_t'(c), a, d);
      end
    end
  endtask

  task automatic wait_until_drained();
    while (bus_beats_pending.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(logic [1:0] idx, logic [4:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      next_valid = in_valid && !in_taken;
      if (!next_valid) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (bus_beats_pending.size() != 0) begin
          beat = bus_beats_pending.pop_front();
          in_command <= beat.command;
          in_bus_address <= beat.bus_address;
          in_write_byte <= beat.write_byte;
          next_valid = 1'b1;
          sent_count++;
          draw_wait(send_calm, send_wait);
        end
      end
      in_valid <= next_valid;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken)
        draw_wait(recv_calm, recv_wait);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one long receiver hold-off so both stages fill and in_ready drops
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_count >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      prg_mask_m = PRG_MASK_RST;
      chr_mask_m = CHR_MASK_RST;
      chr_ram_m = 1'b0;
      shift_bits = '0;
      shift_len = '0;
      mirror_bits = '0;
      prg_mode = PRG_MODE_FIX_LAST;
      chr_4k = 1'b0;
      chr_lo = '0;
      chr_hi = '0;
      prg_page = '0;
      prg_ram_en = 1'b0;
      in_taken = 1'b0;
      out_taken = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PRG_MASK: prg_mask_m = cfg_wdata[3:0];
          CFG_CHR_MASK: chr_mask_m = cfg_wdata;
          CFG_CHR_RAM:  chr_ram_m = cfg_wdata[0];
          default: ;
        endcase
      end
      in_taken = in_valid && in_ready;
      if (in_taken)
        expected_results.push_back(translate_access(cmd_t'(in_command), in_bus_address,
                                                    in_write_byte));
      out_taken = out_valid && out_ready;
      if (out_taken) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result beat: target %0d offset %h we %b mirror %0d",
                     out_target, out_byte_offset, out_write_enable,
                     out_mirroring_mode);
        end else begin
          want = expected_results.pop_front();
          if (out_target !== want.target || out_byte_offset !== want.offset ||
              out_write_enable !== want.we || out_mirroring_mode !== want.mirror) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: exp %0d/%h/%b/%0d got %0d/%h/%b/%0d",
                       want.target, want.offset, want.we, want.mirror, out_target,
                       out_byte_offset, out_write_enable, out_mirroring_mode);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timed out with %0d results outstanding", expected_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [3:0] prg_mask_set;
    logic [4:0] chr_mask_set;
    logic       chr_ram_set;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed accesses at the reset geometry
    queue_beat(CMD_CPU_WR, 16'h8000, 8'h80);
    queue_beat(CMD_CPU_RD, 16'h0000, 8'h00);
    queue_beat(CMD_CPU_WR, 16'h5FFF, 8'hFF);
    queue_beat(CMD_CPU_RD, 16'h6000, 8'h00);
    queue_beat(CMD_CPU_WR, 16'h7FFF, 8'h5A);   // prg ram still disabled
    queue_serial_load(16'hE000, 5'h00);        // prg bank 0, ram enabled
    queue_beat(CMD_CPU_WR, 16'h6000, 8'hFF);
    queue_serial_load(16'h8000, 5'h13);        // mirroring 3, 32k prg, 4k chr
    queue_beat(CMD_CPU_RD, 16'h8000, 8'h00);
    queue_beat(CMD_CPU_RD, 16'hFFFF, 8'h00);
    queue_beat(CMD_PPU_RD, 16'h0000, 8'h00);
    queue_beat(CMD_PPU_RD, 16'h1FFF, 8'h00);
    queue_beat(CMD_PPU_WR, 16'h1000, 8'hA5);   // chr rom ignores writes
    queue_beat(CMD_PPU_WR, 16'h2000, 8'h3C);
    queue_beat(CMD_PPU_RD, 16'hFFFF, 8'h00);   // upper ppu bits ignored
    queue_beat(CMD_CPU_WR, 16'hA000, 8'h01);
    queue_beat(CMD_CPU_WR, 16'hA000, 8'h7E);
    queue_beat(CMD_CPU_WR, 16'hC000, 8'hFF);   // reset partway through a load

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin prg_mask_set = 4'hF; chr_mask_set = 5'h1F; chr_ram_set = 1'b1; end
        1: begin prg_mask_set = 4'h0; chr_mask_set = 5'h00; chr_ram_set = 1'b0; end
        2: begin prg_mask_set = 4'h7; chr_mask_set = 5'h0F; chr_ram_set = 1'b1; end
        3: begin prg_mask_set = 4'h3; chr_mask_set = 5'h01; chr_ram_set = 1'b0; end
        default: begin
          prg_mask_set = 4'($urandom);
          chr_mask_set = 5'($urandom);
          chr_ram_set = 1'($urandom);
        end
      endcase
      wait_until_drained();
      write_config(CFG_PRG_MASK, {1'b0, prg_mask_set});
      write_config(CFG_CHR_MASK, chr_mask_set);
      write_config(CFG_CHR_RAM, {4'd0, chr_ram_set});
      while (bus_beats_pending.size() < PHASE_ITEMS)
        add_random_traffic();
    end

    wait_until_drained();
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
